### rtl/core/cartridge_mapper_43_bank_irq_defines.svh
// Assertion macros used by the checker module.
`ifndef CARTRIDGE_MAPPER_43_BANK_IRQ_DEFINES_SVH
`define CARTRIDGE_MAPPER_43_BANK_IRQ_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define CM43_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cm43 check failed: lbl");

// Value held on the edge after a stalled result transaction.
`define CM43_ASSERT_HOLD(lbl, stall, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (stall) |=> $stable(sig)) \
    else $error("cm43 hold failed: lbl");

`endif

### rtl/core/cm43_pkg.sv
package cm43_pkg;

  localparam logic [1:0] OP_EXP_WR = 2'd0;
  localparam logic [1:0] OP_EXP_RD = 2'd1;
  localparam logic [1:0] OP_PRG_WR = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [15:0] PAGE_SEL_ADDR = 16'h4022;
  localparam logic [15:0] PAGE_SEL_MASK = 16'hF0FF;
  localparam logic [15:0] IRQ_CTRL_ADDR = 16'h8122;
  localparam logic [15:0] ROM_WIN_LO    = 16'h5000;
  localparam logic [15:0] ROM_WIN_HI    = 16'h6000;
  localparam logic [16:0] ROM_WIN_BASE  = 17'(32'h2000 * 8 + 32'h1000);
  localparam logic [2:0]  PAGE_SEL_BITS = 3'h7;
  localparam logic [1:0]  IRQ_ON_BITS   = 2'h3;

  localparam int unsigned COUNT_W    = 24;
  localparam int unsigned STEP_SHIFT = 6;
  localparam logic [COUNT_W-1:0] TICK_STEP  = COUNT_W'(7276);
  localparam logic [COUNT_W-1:0] WRAP_LIMIT = COUNT_W'(32'd4096 << STEP_SHIFT);
  localparam logic [3:0] PAGE_RESET = 4'd4;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic        from_rom;
    logic [16:0] rom_offset;
    logic [7:0]  open_bus_byte;
    logic [3:0]  upper_window_page;
    logic        irq_pulse;
    logic        irq_is_enabled;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PAGE,
    CMD_ROM_RD,
    CMD_OPEN_RD,
    CMD_IRQ_ON,
    CMD_IRQ_OFF,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  page;
    logic [16:0] rom_offset;
    logic [7:0]  open_bus_byte;
  } cmd_t;

  function automatic logic [3:0] page_lookup(input logic [2:0] sel);
    logic [3:0] page;
    case (sel)
      3'd1:    page = 4'd3;
      3'd5:    page = 4'd7;
      3'd6:    page = 4'd5;
      3'd7:    page = 4'd6;
      default: page = 4'd4;
    endcase
    return page;
  endfunction

endpackage

### rtl/core/cartridge_mapper_43_bank_irq.sv
// Bank-switch and scanline IRQ mapper for a game cartridge.
// Input channel (in_valid/in_ready/in_data): one bus event per transaction:
// expansion write, expansion read, program-area write or scanline tick.
// Result channel (out_valid/out_ready/out_data): exactly one result per
// input transaction, in order: ROM offset or open-bus byte for reads, the
// page mapped at 0xC000, the IRQ pulse of a tick and the IRQ enable.
// Path: the accepting edge writes the classified command into a two-entry
// queue; once the output register is free, the back end executes the
// command at the queue head into the output register.
// Throughput: one transaction per cycle while out_ready is held high; the
// state update is a 24-bit add, compare and subtract in the back end.
// Reset (rst_n low, synchronous): queue empty, no result pending, counter
// cleared, IRQ enabled, page 4 mapped at 0xC000.
// Stall: a held result stays in the output register while the back end
// keeps the next command in the queue; in_ready drops only when both
// queue entries are occupied.
module cartridge_mapper_43_bank_irq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cm43_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cm43_pkg::out_item_t out_data
);
  import cm43_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_head_valid;
  cmd_t front_cmd;
  cmd_t head_cmd;

  // Front end: accept and classify the bus event.
  cm43_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (q_push),
    .cmd      (front_cmd)
  );

  // Decouple front and back so either can stall on its own.
  cm43_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (head_cmd)
  );

  // Back end: advance mapper state and register the result.
  cm43_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_head_valid),
    .cmd       (head_cmd),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/core/cm43_front.sv
module cm43_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  cm43_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               push,
  output cm43_pkg::cmd_t     cmd
);
  import cm43_pkg::*;

  logic in_rom_win;

  assign in_ready   = !q_full;
  assign push       = in_valid && !q_full;
  assign in_rom_win = (in_data.cpu_address >= ROM_WIN_LO) &&
                      (in_data.cpu_address < ROM_WIN_HI);

  // Classify the bus event into a command for the back end.
  always_comb begin
    cmd.kind          = CMD_NOP;
    cmd.page          = page_lookup(in_data.write_data[2:0] & PAGE_SEL_BITS);
    cmd.rom_offset    = ROM_WIN_BASE + 17'(in_data.cpu_address - ROM_WIN_LO);
    cmd.open_bus_byte = in_data.cpu_address[15:8];
    case (in_data.opcode)
      OP_EXP_WR: begin
        if ((in_data.cpu_address & PAGE_SEL_MASK) == PAGE_SEL_ADDR) cmd.kind = CMD_PAGE;
      end
      OP_EXP_RD: begin
        cmd.kind = in_rom_win ? CMD_ROM_RD : CMD_OPEN_RD;
      end
      OP_PRG_WR: begin
        if (in_data.cpu_address == IRQ_CTRL_ADDR) begin
          cmd.kind = ((in_data.write_data[1:0] & IRQ_ON_BITS) != 2'd0) ? CMD_IRQ_ON
                                                                        : CMD_IRQ_OFF;
        end
      end
      default: cmd.kind = CMD_TICK;
    endcase
  end

endmodule

### rtl/core/cm43_queue.sv
module cm43_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cm43_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output cm43_pkg::cmd_t head_cmd
);
  import cm43_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

### rtl/core/cm43_back.sv
module cm43_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  cm43_pkg::cmd_t      cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output cm43_pkg::out_item_t out_data
);
  import cm43_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               enable_r, enable_nxt;
  logic [3:0]         page_r, page_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r, out_data_nxt;
  logic [COUNT_W-1:0] tick_cnt;

  assign pop       = cmd_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign tick_cnt  = count_r + TICK_STEP;

  always_comb begin
    count_nxt    = count_r;
    enable_nxt   = enable_r;
    page_nxt     = page_r;
    out_data_nxt = '0;
    case (cmd.kind)
      CMD_PAGE:    page_nxt = cmd.page;
      CMD_ROM_RD: begin
        out_data_nxt.from_rom   = 1'b1;
        out_data_nxt.rom_offset = cmd.rom_offset;
      end
      CMD_OPEN_RD: out_data_nxt.open_bus_byte = cmd.open_bus_byte;
      CMD_IRQ_ON:  enable_nxt = 1'b1;
      CMD_IRQ_OFF: begin
        enable_nxt = 1'b0;
        count_nxt  = '0;
      end
      CMD_TICK: begin
        if (enable_r) begin
          if (tick_cnt >= WRAP_LIMIT) begin
            count_nxt              = tick_cnt - WRAP_LIMIT;
            out_data_nxt.irq_pulse = 1'b1;
          end else begin
            count_nxt = tick_cnt;
          end
        end
      end
      default: ;
    endcase
    out_data_nxt.upper_window_page = page_nxt;
    out_data_nxt.irq_is_enabled    = enable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      enable_r    <= 1'b1;
      page_r      <= PAGE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        count_r  <= count_nxt;
        enable_r <= enable_nxt;
        page_r   <= page_nxt;
      end
      if (pop) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data_r <= out_data_nxt;
  end

endmodule

### rtl/core/cm43_checker.sv
`include "cartridge_mapper_43_bank_irq_defines.svh"

module cm43_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input cm43_pkg::out_item_t out_data
);
  import cm43_pkg::*;

  logic rom_clean;
  logic page_ok;

  assign rom_clean = (out_data.open_bus_byte == 8'd0) &&
                     (out_data.rom_offset[16:12] == ROM_WIN_BASE[16:12]) &&
                     !out_data.irq_pulse;
  assign page_ok   = (out_data.upper_window_page == 4'd3) ||
                     (out_data.upper_window_page == 4'd4) ||
                     (out_data.upper_window_page == 4'd5) ||
                     (out_data.upper_window_page == 4'd6) ||
                     (out_data.upper_window_page == 4'd7);

  `CM43_ASSERT_HOLD(a_out_hold, out_valid && !out_ready, out_data)
  `CM43_ASSERT_IMPL(a_pulse_needs_enable, out_valid && out_data.irq_pulse, out_data.irq_is_enabled)
  `CM43_ASSERT_IMPL(a_rom_read_clean, out_valid && out_data.from_rom, rom_clean)
  `CM43_ASSERT_IMPL(a_page_legal, out_valid, page_ok)

endmodule

bind cartridge_mapper_43_bank_irq cm43_checker u_cm43_checker (.*);
